/* design/wft_pkg.sv */
// Shared types and constants for the single-wire RGB LED chain transmitter.
// Holds item kinds, register indexes, reset values and the result record.
// No dependencies.
`timescale 1ns / 1ps

package wft_pkg;

	// Item kinds carried on s_tuser
	localparam logic [1:0] KIND_WRITE = 2'd0;
	localparam logic [1:0] KIND_SEND  = 2'd1;
	localparam logic [1:0] KIND_TICK  = 2'd2;
	localparam logic [1:0] KIND_NOP   = 2'd3;

	// Configuration register indexes
	localparam logic [1:0] CFG_ONE_HIGH  = 2'd0;
	localparam logic [1:0] CFG_ZERO_HIGH = 2'd1;
	localparam logic [1:0] CFG_PERIOD    = 2'd2;
	localparam logic [1:0] CFG_RESET_LOW = 2'd3;

	// Register reset values
	localparam logic [7:0]  ONE_HIGH_RST  = 8'd17;
	localparam logic [7:0]  ZERO_HIGH_RST = 8'd8;
	localparam logic [7:0]  PERIOD_RST    = 8'd25;
	localparam logic [15:0] RESET_LOW_RST = 16'd1000;

	// Last bit index of a pixel (24 bits: green, red, blue)
	localparam logic [4:0] LAST_BIT = 5'd23;

	// Result queue depth and occupancy width
	localparam int RES_DEPTH = 3;

	typedef logic [1:0] res_cnt_t;
	typedef logic [1:0] res_ptr_t;

	// One result item
	typedef struct packed {
		logic rejected;
		logic busy_res;
		logic line_level;
	} res_t;

endpackage

/* design/wft_out_fifo.sv */
// Three-entry result queue between the item logic and the output channel.
// Depends on wft_pkg for the result record and depth.
`timescale 1ns / 1ps

module wft_out_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  wft_pkg::res_t     push_data,
	output logic              out_valid,
	input  logic              out_ready,
	output wft_pkg::res_t     out_data,
	output wft_pkg::res_cnt_t count
);
	import wft_pkg::*;

	res_t     entry_q [RES_DEPTH];
	res_ptr_t wr_ptr_q;
	res_ptr_t rd_ptr_q;
	res_cnt_t cnt_q;
	logic     pop;

	assign out_valid = (cnt_q != '0);
	assign out_data  = entry_q[rd_ptr_q];
	assign count     = cnt_q;
	assign pop       = out_valid && out_ready;

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == res_ptr_t'(RES_DEPTH - 1)) ? '0 : wr_ptr_q + 2'd1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == res_ptr_t'(RES_DEPTH - 1)) ? '0 : rd_ptr_q + 2'd1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* design/ws2812_frame_transmitter_unit.sv */
// Single-wire RGB LED chain transmitter: pixel store, bit waveform engine, result queue.
// Depends on wft_pkg and wft_out_fifo.
// Path: an item is captured in the input register, then its result is written into the result queue.
// Throughput: one item per cycle; input stalls while queue plus input register hold three, or while clearing.
// Reset: registers take their reset values, then a clearing pass zeroes the pixel
// store entry by entry, during which s_tready stays low (cfg writes still taken).
`timescale 1ns / 1ps

module ws2812_frame_transmitter_unit #(
	parameter int PIXEL_COUNT = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// Item input
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // pixel_index[3:0], red[11:4], green[19:12], blue[27:20]
	input  logic [1:0]  s_tuser,   // kind[1:0]
	// Result output
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // line_level[0], busy_res[1], rejected[2]
	// Configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import wft_pkg::*;

	localparam int AW = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
	localparam logic [AW-1:0] LAST_PIX = AW'(PIXEL_COUNT - 1);
	localparam logic [10:0]   PIX_LIMIT = 11'(PIXEL_COUNT);

	// Send sequencer codes
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_SEND = 2'd1;
	localparam logic [1:0] PH_GAP  = 2'd2;

	// Configuration registers
	logic [7:0]  one_high_q;
	logic [7:0]  zero_high_q;
	logic [7:0]  period_q;
	logic [15:0] reset_low_q;

	// Input stage
	logic          vld_s1;
	logic [1:0]    kind_s1;
	logic [3:0]    idx_s1;
	logic [7:0]    red_s1;
	logic [7:0]    green_s1;
	logic [7:0]    blue_s1;

	// Sequencer state
	logic [1:0]    phase_q;
	logic [AW-1:0] pix_q;
	logic [4:0]    bit_q;
	logic [7:0]    tick_q;
	logic [15:0]   gap_q;
	logic [23:0]   shift_q;
	logic          line_q;

	// Store clearing after reset
	logic          clr_active_q;
	logic [AW-1:0] clr_addr_q;

	// Pixel store, green-red-blue order
	logic [23:0]   pix_mem [PIXEL_COUNT];
	logic [23:0]   rd_data_q;
	logic [AW-1:0] rd_addr;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [23:0]   mem_wdata;

	// Next-state values
	logic [1:0]    phase_d;
	logic [AW-1:0] pix_d;
	logic [4:0]    bit_d;
	logic [7:0]    tick_d;
	logic [15:0]   gap_d;
	logic [23:0]   shift_d;
	logic          line_d;
	logic          rej_d;
	logic          busy;
	logic          wr_hit;
	logic [10:0]   idx_ext;
	logic [AW-1:0] next_pix;
	logic [7:0]    high_len;
	logic [7:0]    period_eff;
	logic [15:0]   gap_len;
	logic [7:0]    tick_inc;
	logic [15:0]   gap_inc;

	// Result queue
	res_t     res_d;
	res_t     res_out;
	res_cnt_t res_cnt;
	logic     s_accept;

	// Input may enter while no clearing pass runs and the queue has room for everything in flight
	assign s_tready = !clr_active_q && ((3'(res_cnt) + 3'(vld_s1)) < 3'(RES_DEPTH));
	assign s_accept = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	// Configuration register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			one_high_q  <= ONE_HIGH_RST;
			zero_high_q <= ZERO_HIGH_RST;
			period_q    <= PERIOD_RST;
			reset_low_q <= RESET_LOW_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_ONE_HIGH:  one_high_q  <= cfg_data[7:0];
				CFG_ZERO_HIGH: zero_high_q <= cfg_data[7:0];
				CFG_PERIOD:    period_q    <= cfg_data[7:0];
				CFG_RESET_LOW: reset_low_q <= cfg_data;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= s_accept;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			kind_s1  <= s_tuser;
			idx_s1   <= s_tdata[3:0];
			red_s1   <= s_tdata[11:4];
			green_s1 <= s_tdata[19:12];
			blue_s1  <= s_tdata[27:20];
		end
	end

	// Item logic
	assign busy       = (phase_q != PH_IDLE);
	assign idx_ext    = {7'd0, idx_s1};
	assign next_pix   = (pix_q == LAST_PIX) ? '0 : pix_q + AW'(1);
	assign high_len   = shift_q[23] ? one_high_q : zero_high_q;
	assign period_eff = (period_q == 8'd0) ? 8'd1 : period_q;
	assign gap_len    = (reset_low_q == 16'd0) ? 16'd1 : reset_low_q;
	assign tick_inc   = tick_q + 8'd1;
	assign gap_inc    = gap_q + 16'd1;
	assign wr_hit     = vld_s1 && (kind_s1 == KIND_WRITE) && !busy && (idx_ext < PIX_LIMIT);

	always_comb begin
		phase_d = phase_q;
		pix_d   = pix_q;
		bit_d   = bit_q;
		tick_d  = tick_q;
		gap_d   = gap_q;
		shift_d = shift_q;
		line_d  = line_q;
		rej_d   = 1'b0;
		if (vld_s1) begin
			unique case (kind_s1)
				KIND_WRITE: begin
					rej_d = busy;
				end
				KIND_SEND: begin
					if (busy) begin
						rej_d = 1'b1;
					end else begin
						phase_d = PH_SEND;
						pix_d   = '0;
						bit_d   = '0;
						tick_d  = '0;
						gap_d   = '0;
						shift_d = rd_data_q;
					end
				end
				KIND_TICK: begin
					unique case (phase_q)
						PH_SEND: begin
							line_d = (tick_q < high_len);
							tick_d = tick_inc;
							// End of one bit period
							if ((tick_inc >= period_eff) || (tick_inc == 8'd0)) begin
								tick_d  = '0;
								shift_d = {shift_q[22:0], 1'b0};
								bit_d   = bit_q + 5'd1;
								if (bit_q == LAST_BIT) begin
									bit_d = '0;
									if (pix_q == LAST_PIX) begin
										pix_d   = '0;
										gap_d   = '0;
										shift_d = '0;
										phase_d = PH_GAP;
									end else begin
										pix_d   = next_pix;
										shift_d = rd_data_q;
									end
								end
							end
						end
						PH_GAP: begin
							line_d = 1'b0;
							gap_d  = gap_inc;
							if ((gap_inc >= gap_len) || (gap_inc == 16'd0)) begin
								gap_d   = '0;
								phase_d = PH_IDLE;
							end
						end
						default: begin
							line_d = 1'b0;
						end
					endcase
				end
				KIND_NOP: begin
					rej_d = 1'b0;
				end
			endcase
		end
		res_d.line_level = line_d;
		res_d.busy_res   = (phase_d != PH_IDLE);
		res_d.rejected   = rej_d;
	end

	// Sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			pix_q   <= '0;
			bit_q   <= '0;
			tick_q  <= '0;
			gap_q   <= '0;
			shift_q <= '0;
			line_q  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			pix_q   <= pix_d;
			bit_q   <= bit_d;
			tick_q  <= tick_d;
			gap_q   <= gap_d;
			shift_q <= shift_d;
			line_q  <= line_d;
		end
	end

	// Clearing pass over the pixel store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_addr_q   <= '0;
		end else if (clr_active_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == LAST_PIX) begin
				clr_active_q <= 1'b0;
			end
		end
	end

	// Store port: clearing writes, pixel writes; read follows the next pixel to send
	assign mem_we    = clr_active_q || wr_hit;
	assign mem_waddr = clr_active_q ? clr_addr_q : idx_ext[AW-1:0];
	assign mem_wdata = clr_active_q ? 24'd0 : {green_s1, red_s1, blue_s1};
	assign rd_addr   = (phase_q == PH_SEND) ? next_pix : '0;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			pix_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_we && (mem_waddr == rd_addr)) begin
			rd_data_q <= mem_wdata;
		end else begin
			rd_data_q <= pix_mem[rd_addr];
		end
	end

	// Result queue
	wft_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (vld_s1),
		.push_data (res_d),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (res_out),
		.count     (res_cnt)
	);

	assign m_tdata = {5'd0, res_out.rejected, res_out.busy_res, res_out.line_level};

`ifndef SYNTHESIS
	// No item enters while the store is being cleared
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_active_q |-> !s_tready)
		else $error("item accepted during store clearing");

	// Items in flight never exceed the result queue
	a_inflight_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(3'(res_cnt) + 3'(vld_s1)) <= 3'(RES_DEPTH))
		else $error("result queue overrun");

	// Bit position stays within one pixel
	a_bit_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_q <= LAST_BIT)
		else $error("bit counter out of range");

	// Line is low whenever no frame or latch gap is running
	a_line_low_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE) |-> !line_q)
		else $error("line high while idle");
`endif

endmodule
